// ----- hdl/bpa_pkg.sv -----
`default_nettype none
package bpa_pkg;

  localparam int TotalPages = 4096;
  localparam int WordBits   = 64;
  localparam int WordCount  = TotalPages / WordBits;
  localparam int PageW      = $clog2(TotalPages);
  localparam int CountW     = PageW + 1;
  localparam int WordW      = $clog2(WordCount);
  localparam int BitW       = $clog2(WordBits);
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 13;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_ENABLE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_PAGES  = 1'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PageW-1:0]  start_page;
    logic [CountW-1:0] run_length;
  } bpa_in_t;

  typedef struct packed {
    logic             ok;
    logic [PageW-1:0] found_page;
  } bpa_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request and clear scan state
    logic rd;         // issue a read of the word at the read address
    logic scan;       // rd data valid: scan its bits
    logic wr;         // write modified word
    logic set_wr;     // start the write-back phase at run start
    logic step;       // advance write pointer by one word
  } bpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;      // scan of current word completed a run
    logic scan_end;   // current word is the last managed one
    logic wr_done;    // write word covers the run end
    logic wr_none;    // nothing to write
  } bpa_sts_t;

endpackage
`default_nettype wire

// ----- hdl/bpa_datapath.sv -----
`default_nettype none
module bpa_datapath
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire bpa_in_t           req,
  input  wire logic [CountW-1:0] lim,
  input  wire bpa_cmd_t          cmd,
  output bpa_sts_t               sts,
  output logic [PageW-1:0]       first_page
);

  logic [WordBits-1:0] mem [WordCount];
  logic [WordBits-1:0] rdata_r;
  logic [WordW-1:0]    raddr;
  logic [CountW-1:0]   len_r, run_r, run_nxt, first_r, first_nxt;
  logic [CountW-1:0]   wbeg_r, wend_r, wend_nxt, wptr_r;
  logic                used_r;
  logic                fnd;
  logic [CountW-1:0]   wbase;
  logic [WordBits-1:0] wmask, wdata;
  logic [WordW:0]      sw_r;

  // scan word counter and read address
  assign raddr = cmd.load ? '0 :
                 cmd.scan ? sw_r[WordW-1:0] : wptr_r[PageW-1:BitW];

  always_ff @(posedge clk) begin
    if (cmd.load) sw_r <= cmd.rd ? (WordW+1)'(1) : '0;
    else if (cmd.rd) sw_r <= sw_r + 1'b1;
    if (cmd.rd) rdata_r <= mem[raddr];
    if (cmd.wr) mem[wptr_r[PageW-1:BitW]] <= wdata;
  end

  // bit scan over one word: free run length at every bit in parallel
  always_comb begin
    logic [BitW:0]       lu [WordBits];
    logic [CountW-1:0]   rb [WordBits];
    logic [WordBits-1:0] hv;
    logic [CountW-1:0]   base;
    logic [BitW-1:0]     h;
    logic [BitW:0]       fb;
    base  = {(sw_r - 1'b1), BitW'(0)};
    lu[0] = rdata_r[0] ? (BitW+1)'(1) : '0;
    for (int b = 1; b < WordBits; b++)
      lu[b] = rdata_r[b] ? (BitW+1)'(b + 1) : lu[b-1];
    for (int b = 0; b < WordBits; b++) begin
      rb[b] = (lu[b] == '0) ? run_r + CountW'(b + 1) : CountW'(b + 1) - CountW'(lu[b]);
      hv[b] = !rdata_r[b] && (base + CountW'(b) < lim) && (rb[b] >= len_r);
    end
    h = '0;
    for (int b = WordBits - 1; b >= 0; b--)
      if (hv[b]) h = BitW'(b);
    if (|hv) begin
      fnd     = 1'b1;
      run_nxt = rb[h];
      fb      = lu[h];
    end else begin
      fnd     = 1'b0;
      run_nxt = rdata_r[WordBits-1] ? '0 : rb[WordBits-1];
      fb      = lu[WordBits-1];
    end
    first_nxt = (fb == '0 && run_r != '0) ? first_r : base + CountW'(fb);
  end

  // run end clamped to managed count
  always_comb begin
    logic [CountW:0] e;
    e = {1'b0, cmd.load ? {1'b0, req.start_page} : first_r} + {1'b0, len_r};
    if (cmd.load) e = {1'b0, 1'b0, req.start_page} + {1'b0, req.run_length};
    if (e > {1'b0, lim}) e = {1'b0, lim};
    wend_nxt = e[CountW-1:0];
  end

  // write word: masked set or clear of the range within it
  assign wbase = {wptr_r[CountW-1:BitW], BitW'(0)};
  always_comb begin
    for (int b = 0; b < WordBits; b++)
      wmask[b] = (wbase + CountW'(b) >= wbeg_r) && (wbase + CountW'(b) < wend_r);
    wdata = used_r ? (rdata_r | wmask) : (rdata_r & ~wmask);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r   <= req.run_length;
      run_r   <= '0;
      first_r <= '0;
      used_r  <= req.kind != KIND_FREE;
      wbeg_r  <= {1'b0, req.start_page};
      wend_r  <= wend_nxt;
      wptr_r  <= {1'b0, req.start_page};
    end else if (cmd.scan) begin
      run_r   <= run_nxt;
      first_r <= first_nxt;
    end else if (cmd.set_wr) begin
      wbeg_r <= first_r;
      wend_r <= wend_nxt;
      wptr_r <= first_r;
    end else if (cmd.step) begin
      wptr_r <= wbase + CountW'(WordBits);
    end
  end

  // read address during write phase shares the port
  assign sts.found    = fnd;
  assign sts.scan_end = ({sw_r, BitW'(0)} >= lim);
  assign sts.wr_done  = (wbase + CountW'(WordBits) >= wend_r);
  assign sts.wr_none  = (wbeg_r >= wend_r);
  assign first_page   = first_r[PageW-1:0];

endmodule
`default_nettype wire

// ----- hdl/bpa_control.sv -----
`default_nettype none
module bpa_control
  import bpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire bpa_in_t in_data,
  input  wire logic enable,
  input  wire logic [CountW-1:0] lim,
  input  wire bpa_sts_t sts,
  output bpa_cmd_t  cmd,
  output logic      res_ok,
  output logic      res_alloc,
  output logic      res_valid,
  input  wire logic res_taken
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_SRD  = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic ok_r, ok_nxt, alloc_r, alloc_nxt;
  logic take;

  assign in_stall  = st_r != S_IDLE || res_valid;
  assign take      = in_valid && !in_stall;
  assign res_valid = st_r == S_DONE;
  assign res_ok    = ok_r;
  assign res_alloc = alloc_r;

  always_comb begin
    st_nxt = st_r; ok_nxt = ok_r; alloc_nxt = alloc_r;
    cmd = '0;
    case (st_r)
      S_IDLE: if (take) begin
        cmd.load = 1'b1;
        ok_nxt = 1'b0; alloc_nxt = 1'b0;
        if (!enable || in_data.run_length == '0 || in_data.kind == KIND_BAD) st_nxt = S_DONE;
        else if (in_data.kind == KIND_ALLOC) begin
          alloc_nxt = 1'b1;
          if (in_data.run_length > lim) st_nxt = S_DONE;
          else begin cmd.rd = 1'b1; st_nxt = S_SCAN; end
        end else begin
          ok_nxt = 1'b1; st_nxt = S_WRD;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin ok_nxt = 1'b1; st_nxt = S_SRD; end
        else if (sts.scan_end) st_nxt = S_DONE;
        else cmd.rd = 1'b1;
      end
      S_SRD: begin cmd.set_wr = 1'b1; st_nxt = S_WRD; end
      S_WRD: begin
        if (sts.wr_none) st_nxt = S_DONE;
        else st_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.wr_done) st_nxt = S_DONE;
        else begin cmd.step = 1'b1; st_nxt = S_WRD; end
      end
      S_DONE: if (res_taken) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_WRD && !sts.wr_none) cmd.rd = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    ok_r <= ok_nxt; alloc_r <= alloc_nxt;
  end

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> in_stall) else $error("accepted while busy");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(st_r) == S_WRD) else $error("write without read");
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_SCAN && sts.found |=> ok_r) else $error("found lost");

endmodule
`default_nettype wire

// ----- hdl/bitmap_page_allocator.sv -----
// bitmap first-fit page allocator, one bit per page, set = used
// input transfer: in_valid/in_stall with in_data (kind, start_page, run_length)
// result transfer: out_valid/out_stall with out_data (ok, found_page), one per request
// config: cfg_we, cfg_index (0 enable, 1 pages_managed), cfg_data; write only when idle
// one request at a time; input stalls from its transfer until its result transfers
// a rejected request goes straight to the result; a free or reserve reads and writes
// back each word it touches (none when no page is in range); an allocation scans
// words until a run fits, then reads and writes back the words of the run, or gives
// its result after the scan when no run fits; the next request can transfer in the
// cycle after the result transfers; the bitmap memory is single-port, one word read
// or written per cycle
// reset: enable 0, pages_managed 4096; a sweep then writes every word free,
// input stalled meanwhile
// when out_stall is high the result holds and no new request is taken
`default_nettype none
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bpa_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bpa_out_t                 out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic              en_r;
  logic [CountW-1:0] pm_r, lim;
  logic              clr_r;
  logic [WordW:0]    clr_cnt_r;
  bpa_cmd_t          cmd, dcmd;
  bpa_sts_t          sts;
  logic [PageW-1:0]  first_page;
  logic              res_ok, res_alloc, busy_stall;
  bpa_in_t           dreq;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0; pm_r <= CountW'(TotalPages);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: en_r <= cfg_data[0];
        REG_PAGES:  pm_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end
  assign lim = (pm_r > CountW'(TotalPages)) ? CountW'(TotalPages) : pm_r;

  // clearing sweep after reset: writes zero word by word through the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin clr_r <= 1'b1; clr_cnt_r <= '0; end
    else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == (WordW+1)'(WordCount)) clr_r <= 1'b0;
    end
  end

  bpa_control u_ctl (
    .clk, .rst_n, .in_valid(in_valid && !clr_r), .in_stall(busy_stall), .in_data,
    .enable(en_r), .lim, .sts, .cmd, .res_ok, .res_alloc, .res_valid(out_valid),
    .res_taken(!out_stall)
  );
  assign in_stall = busy_stall || clr_r;

  // during the sweep load a free of one word and write back the word loaded before
  always_comb begin
    dcmd = cmd; dreq = in_data;
    if (clr_r) begin
      dcmd = '0;
      dcmd.load = clr_cnt_r != (WordW+1)'(WordCount);
      dcmd.wr   = clr_cnt_r != '0;
      dreq.kind = KIND_FREE;
      dreq.start_page = {clr_cnt_r[WordW-1:0], BitW'(0)};
      dreq.run_length = CountW'(WordBits);
    end
  end

  bpa_datapath u_dp (
    .clk, .req(dreq), .lim(clr_r ? CountW'(TotalPages) : lim), .cmd(dcmd), .sts,
    .first_page
  );

  assign out_data.ok         = res_ok;
  assign out_data.found_page = (res_ok && res_alloc) ? first_page : '0;

  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.found_page == '0) else $error("page not zero");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall) else $error("taken during sweep");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");

endmodule
`default_nettype wire

// ----- tb/sv/bpa_checker.sv -----
`default_nettype none
module bpa_checker
  import bpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire bpa_in_t             in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire bpa_out_t            out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       results_seen,
  output int                       allocs_granted
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the page bitmap and registers
  logic [TotalPages-1:0] used_map;
  logic                  enabled;
  logic [CfgDataW-1:0]   managed_reg;
  bpa_out_t              grant_q[$];

  // mark or clear a run, clipped to the managed pages
  function automatic void mark_run(int first, int len, int lim, logic val);
    int stop;
    stop = first + len;
    if (stop > lim) stop = lim;
    for (int p = first; p < stop; p++) used_map[p] = val;
  endfunction

  // expected outcome of one request, updates the mirror
  function automatic bpa_out_t serve_request(bpa_in_t r);
    bpa_out_t res;
    int lim, len, run, first;
    res = '0;
    lim = (managed_reg > TotalPages) ? TotalPages : int'(managed_reg);
    len = int'(r.run_length);
    run = 0;
    first = 0;
    if (enabled && len != 0) begin
      case (r.kind)
        KIND_ALLOC: begin
          for (int p = 0; p < lim; p++) begin
            if (used_map[p]) begin
              run = 0;
            end else begin
              if (run == 0) first = p;
              run++;
              if (run >= len) begin
                mark_run(first, len, lim, 1'b1);
                res.ok = 1'b1;
                res.found_page = first[PageW-1:0];
                break;
              end
            end
          end
        end
        KIND_FREE: begin
          mark_run(int'(r.start_page), len, lim, 1'b0);
          res.ok = 1'b1;
        end
        KIND_RESERVE: begin
          mark_run(int'(r.start_page), len, lim, 1'b1);
          res.ok = 1'b1;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  assign pending = grant_q.size();

  always @(posedge clk) begin
    bpa_out_t want;
    if (!rst_n) begin
      used_map = '0;
      enabled = 1'b0;
      managed_reg = 13'd4096;
      grant_q.delete();
      errors = 0;
      results_seen = 0;
      allocs_granted = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_ENABLE) enabled = cfg_data[0];
        else if (cfg_index == REG_PAGES) managed_reg = cfg_data;
      end
      // result transfer
      if (out_valid && !out_stall) begin
        results_seen++;
        if (grant_q.size() == 0) begin
          $error("result transfer with nothing expected: ok=%0d found_page=%0d",
                 out_data.ok, out_data.found_page);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            errors++;
          end
          if (out_data.found_page !== want.found_page) begin
            $error("found_page: expected %0d, got %0d", want.found_page, out_data.found_page);
            errors++;
          end
        end
      end
      // input transfer
      if (in_valid && !in_stall) begin
        want = serve_request(in_data);
        if (in_data.kind == KIND_ALLOC && want.ok) allocs_granted++;
        grant_q.push_back(want);
      end
    end
  end

  final if (grant_q.size() != 0) $display("checker: %0d results never arrived", grant_q.size());
endmodule
`default_nettype wire

// ----- tb/sv/bitmap_page_allocator_tb.sv -----
`default_nettype none
module bitmap_page_allocator_tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bpa_in_t             in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bpa_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int  errors, pending, results_seen, allocs_granted;
  int  cycles = 0;
  int  stall_left = 0;
  bit  calm;
  bit  quiet;
  int  managed_now;
  int  requests_sent;

  bitmap_page_allocator dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  bpa_checker scoreboard (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .results_seen, .allocs_granted
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 10);
    end
  end

  // one request transfer, with an occasional gap ahead of it
  task automatic send_request(bit [1:0] kind, int start, int len);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.kind <= kind;
    in_data.start_page <= start[PageW-1:0];
    in_data.run_length <= len[CountW-1:0];
    requests_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until the block has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_regs(bit en, int pages);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data <= {{(CfgDataW-1){1'b0}}, en};
    @(posedge clk);
    cfg_index <= REG_PAGES;
    cfg_data <= pages[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    managed_now = (pages > TotalPages) ? TotalPages : pages;
  endtask

  // mostly alloc/free churn with small runs, some reserves and odd requests
  task automatic random_request();
    int pick, cap;
    pick = $urandom_range(0, 99);
    cap = (managed_now > 0) ? managed_now - 1 : 0;
    if (pick < 48) begin
      if ($urandom_range(0, 19) == 0) send_request(KIND_ALLOC, $urandom_range(0, 4095),
                                                   $urandom_range(1, managed_now + 2));
      else send_request(KIND_ALLOC, $urandom_range(0, 4095), $urandom_range(1, 32));
    end else if (pick < 82) begin
      send_request(KIND_FREE, $urandom_range(0, cap), $urandom_range(1, 64));
    end else if (pick < 92) begin
      send_request(KIND_RESERVE, $urandom_range(0, cap), $urandom_range(1, 16));
    end else if (pick < 95) begin
      send_request(KIND_FREE, $urandom_range(0, 4095), $urandom_range(1, 4096));
    end else if (pick < 98) begin
      send_request(KIND_BAD, $urandom_range(0, 4095), $urandom_range(0, 4096));
    end else begin
      send_request(2'($urandom_range(0, 2)), $urandom_range(0, 4095), 0);
    end
  endtask

  initial begin
    int phase_pages[7] = '{4096, 100, 1, 0, 8191, 300, 4096};
    int phase_items[7] = '{300, 250, 30, 30, 250, 250, 200};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    calm = 1'b0;
    quiet = 1'b0;
    managed_now = TotalPages;
    requests_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset: everything rejected
    send_request(KIND_ALLOC, 0, 1);
    send_request(KIND_RESERVE, 5, 3);
    drain();

    // directed corners with the full bitmap
    set_regs(1'b1, 4096);
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_ALLOC, 4095, 1);
    send_request(KIND_ALLOC, 0, 4096);
    send_request(KIND_FREE, 0, 1);
    send_request(KIND_ALLOC, 0, 4096);
    send_request(KIND_ALLOC, 0, 1);
    send_request(KIND_FREE, 0, 4096);
    send_request(KIND_RESERVE, 4095, 4096);
    send_request(KIND_ALLOC, 0, 4095);
    send_request(KIND_ALLOC, 0, 1);
    send_request(KIND_FREE, 2730, 64);
    send_request(KIND_FREE, 1365, 5);
    send_request(KIND_ALLOC, 0, 5);
    send_request(KIND_ALLOC, 0, 65);
    send_request(KIND_ALLOC, 0, 64);
    send_request(KIND_BAD, 4095, 4096);
    send_request(KIND_RESERVE, 0, 0);
    send_request(KIND_FREE, 0, 8191 & 4096);
    send_request(KIND_RESERVE, 63, 2);
    send_request(KIND_FREE, 64, 1);
    send_request(KIND_ALLOC, 0, 1);
    drain();

    // random phases over several page counts, the disabled state included
    for (int ph = 0; ph < 7; ph++) begin
      set_regs(1'b1, phase_pages[ph]);
      send_request(KIND_FREE, 0, 4096);
      calm = (ph == 2);
      quiet = (ph == 6);
      for (int i = 0; i < phase_items[ph]; i++) random_request();
      drain();
      if (ph == 3) begin
        set_regs(1'b0, 2000);
        for (int i = 0; i < 20; i++) random_request();
        drain();
      end
    end

    $display("sent %0d requests over page counts 0..8191 incl. disabled; %0d results checked",
             requests_sent, results_seen);
    $display("%0d allocations granted, stalls and gaps on both sides", allocs_granted);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
